@@ hw/rtl/lipf_pkg.sv @@
`default_nettype none
// Package for the lidar isolated point filter: field widths, register indexes,
// reset values and shared types. No dependencies.
package lipf_pkg;

    localparam int RANGE_W = 17;
    localparam int RATIO_W = 16;
    localparam int GAP_W   = 16;
    localparam int CFG_W   = 17;
    localparam int FRAC_W  = 15;
    // range * ratio + gap * 2^15 stays below 2^34
    localparam int THR_W   = RANGE_W + RATIO_W + 1;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_DISTANCE_RATIO = 2'd0;
    localparam t_cfg_index CFG_MIN_GAP_MM     = 2'd1;
    localparam t_cfg_index CFG_INVALID_CODE   = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RESET   = 16'd846;
    localparam logic [GAP_W-1:0]   GAP_RESET     = 16'd30;
    localparam logic [RANGE_W-1:0] INVALID_RESET = 17'd100000;

    typedef enum logic [2:0] {
        FILL_EMPTY = 3'b001,
        FILL_ONE   = 3'b010,
        FILL_TWO   = 3'b100
    } t_fill;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               scan_end;
    } t_result;

endpackage
`default_nettype wire

@@ hw/rtl/lidar_isolated_point_filter.sv @@
`default_nettype none
// Lidar isolated point filter top level; uses lipf_pkg.
// A held sample enters the output queue when the request that releases it (the next sample,
// or its own scan end) is processed from the input register. Throughput: one request per
// cycle, held off by o_stall from the 4-entry output queue that takes both scan-end results.
// Reset (synchronous, active low) empties the window and queue and restores register defaults.
module lidar_isolated_point_filter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire lipf_pkg::t_cfg_index    i_cfg_index,
    input  wire [lipf_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [lipf_pkg::RANGE_W-1:0]  i_range_mm,
    input  wire                          i_scan_end,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [lipf_pkg::RANGE_W-1:0] o_range_out_mm,
    output logic                         o_scan_end_out
);
    import lipf_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // configuration
    logic [RATIO_W-1:0] r_ratio;
    logic [GAP_W-1:0]   r_gap;
    logic [RANGE_W-1:0] r_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio   <= RATIO_RESET;
            r_gap     <= GAP_RESET;
            r_invalid <= INVALID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISTANCE_RATIO: r_ratio   <= i_cfg_data[RATIO_W-1:0];
                CFG_MIN_GAP_MM:     r_gap     <= i_cfg_data[GAP_W-1:0];
                CFG_INVALID_CODE:   r_invalid <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register with the sample's threshold
    logic               r_in_valid;
    logic [RANGE_W-1:0] r_in_range;
    logic               r_in_last;
    logic [THR_W-1:0]   r_in_thr;
    logic [THR_W-1:0]   n_in_thr;
    logic               in_acc;
    logic               proc_fire;
    logic               q_space;

    assign n_in_thr = THR_W'(i_range_mm) * THR_W'(r_ratio)
                    + {{(THR_W-GAP_W-FRAC_W){1'b0}}, r_gap, {FRAC_W{1'b0}}};

    assign o_stall   = r_in_valid && !q_space;
    assign in_acc    = i_valid && !o_stall;
    assign proc_fire = r_in_valid && q_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_range <= i_range_mm;
            r_in_last  <= i_scan_end;
            r_in_thr   <= n_in_thr;
        end
    end

    // window
    t_fill              r_fill;
    t_fill              n_fill;
    logic [RANGE_W-1:0] r_mid;
    logic [RANGE_W-1:0] r_old;
    logic [THR_W-1:0]   r_mid_thr;
    logic [THR_W-1:0]   r_old_thr;

    logic [RANGE_W-1:0] diff_old;
    logic [RANGE_W-1:0] diff_new;
    logic               jump_old;
    logic               jump_new;
    logic               isolated;
    logic               emit_mid;
    t_result            res_mid;
    t_result            res_last;

    assign diff_old = (r_mid >= r_old) ? r_mid - r_old : r_old - r_mid;
    assign diff_new = (r_mid >= r_in_range) ? r_mid - r_in_range : r_in_range - r_mid;
    assign jump_old = {{(THR_W-RANGE_W-FRAC_W){1'b0}}, diff_old, {FRAC_W{1'b0}}} > r_old_thr;
    assign jump_new = {{(THR_W-RANGE_W-FRAC_W){1'b0}}, diff_new, {FRAC_W{1'b0}}} > r_in_thr;

    always_comb begin
        isolated = 1'b0;
        emit_mid = 1'b0;
        n_fill   = r_fill;
        case (r_fill)
            FILL_EMPTY: begin
                n_fill = FILL_ONE;
            end
            FILL_ONE: begin
                emit_mid = 1'b1;
                n_fill   = FILL_TWO;
            end
            FILL_TWO: begin
                emit_mid = 1'b1;
                isolated = (r_mid != r_invalid) && (r_mid != '0) && jump_old && jump_new;
                n_fill   = FILL_TWO;
            end
            default: begin
                n_fill = FILL_EMPTY;
            end
        endcase
        if (r_in_last) begin
            n_fill = FILL_EMPTY;
        end
    end

    assign res_mid.range_mm  = isolated ? r_invalid : r_mid;
    assign res_mid.scan_end  = 1'b0;
    assign res_last.range_mm = r_in_range;
    assign res_last.scan_end = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL_EMPTY;
        end else if (proc_fire) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_old     <= r_mid;
            r_old_thr <= r_mid_thr;
            r_mid     <= r_in_range;
            r_mid_thr <= r_in_thr;
        end
    end

    // output queue
    t_result             r_queue [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   push_n;
    logic                pop;
    t_result             wr_first;

    assign push_n   = proc_fire ? QCNT_W'(emit_mid) + QCNT_W'(r_in_last) : '0;
    assign pop      = o_valid && !i_stall;
    assign q_space  = r_count <= QCNT_W'(QDEPTH - 2);
    assign wr_first = emit_mid ? res_mid : res_last;

    always_ff @(posedge i_clk) begin
        if (push_n != '0) begin
            r_queue[r_wr_ptr] <= wr_first;
        end
        if (push_n == QCNT_W'(2)) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[QPTR_W-1:0];
            r_rd_ptr <= r_rd_ptr + QPTR_W'(pop);
            r_count  <= r_count + push_n - QCNT_W'(pop);
        end
    end

    assign o_valid        = r_count != '0;
    assign o_range_out_mm = r_queue[r_rd_ptr].range_mm;
    assign o_scan_end_out = r_queue[r_rd_ptr].scan_end;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("output queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_last |=> r_fill == FILL_EMPTY)
        else $error("window not emptied at scan end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && push_n == '0 |=> r_count == $past(r_count) - QCNT_W'(1))
        else $error("queue count lost a pop");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_fill == FILL_EMPTY && !r_in_last |-> push_n == '0)
        else $error("first sample of scan emitted early");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lidar_isolated_point_filter: drives range requests in scans,
// predicts the filtered stream and compares every result. Depends on lipf_pkg and the filter.
module tb_top;
    import lipf_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    t_cfg_index         i_cfg_index    = CFG_DISTANCE_RATIO;
    logic [CFG_W-1:0]   i_cfg_data     = '0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic [RANGE_W-1:0] i_range_mm     = '0;
    logic               i_scan_end     = 1'b0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic [RANGE_W-1:0] o_range_out_mm;
    logic               o_scan_end_out;

    // predictor copy of registers and sample window
    logic [RATIO_W-1:0] ratio_q15   = RATIO_RESET;
    logic [GAP_W-1:0]   gap_mm      = GAP_RESET;
    logic [RANGE_W-1:0] invalid_mm  = INVALID_RESET;
    logic [RANGE_W-1:0] prev_sample = '0;
    logic [RANGE_W-1:0] held_sample = '0;
    t_fill              window_fill = FILL_EMPTY;
    t_result            expected_samples[$];
    int unsigned        error_count = 0;

    // sender and receiver idling
    logic        sender_gaps   = 1'b0;
    int unsigned burst_left    = 0;
    t_stall_mode stall_mode    = STALL_NONE;
    logic [7:0]  stall_pattern = '0;
    logic [2:0]  pattern_pos   = '0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;

    lidar_isolated_point_filter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_range_mm     (i_range_mm),
        .i_scan_end     (i_scan_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_range_out_mm (o_range_out_mm),
        .o_scan_end_out (o_scan_end_out)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // exact jump test, no rounding: |mid - nb| * 2^15 > nb * ratio + gap * 2^15
    function automatic logic exceeds_gap(input logic [RANGE_W-1:0] mid,
                                         input logic [RANGE_W-1:0] nb);
        logic [RANGE_W-1:0] diff;
        logic [THR_W-1:0]   lhs;
        logic [THR_W-1:0]   rhs;
        diff = (mid >= nb) ? mid - nb : nb - mid;
        lhs  = THR_W'(diff) << FRAC_W;
        rhs  = THR_W'(nb) * THR_W'(ratio_q15) + (THR_W'(gap_mm) << FRAC_W);
        return lhs > rhs;
    endfunction

    function automatic void queue_expected(input t_result res);
        expected_samples = {expected_samples, res};
    endfunction

    function automatic void predict_window(input logic [RANGE_W-1:0] sample,
                                           input logic last);
        t_result res;
        res.range_mm = held_sample;
        res.scan_end = 1'b0;
        if (window_fill == FILL_ONE) begin
            queue_expected(res);
        end else if (window_fill == FILL_TWO) begin
            if (held_sample != invalid_mm && held_sample != '0 &&
                exceeds_gap(held_sample, prev_sample) && exceeds_gap(held_sample, sample)) begin
                res.range_mm = invalid_mm;
            end
            queue_expected(res);
        end
        if (window_fill != FILL_EMPTY) begin
            prev_sample = held_sample;
            window_fill = FILL_TWO;
        end else begin
            window_fill = FILL_ONE;
        end
        held_sample = sample;
        if (last) begin
            res.range_mm = sample;
            res.scan_end = 1'b1;
            queue_expected(res);
            prev_sample = '0;
            held_sample = '0;
            window_fill = FILL_EMPTY;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [RANGE_W-1:0] got,
                                   input logic [RANGE_W-1:0] want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_sample(input logic [RANGE_W-1:0] range_mm, input logic last);
        i_valid    <= 1'b1;
        i_range_mm <= range_mm;
        i_scan_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_window(range_mm, last);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_all_results;
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // three writes on consecutive edges, enable lowered once at the end
    task automatic program_registers(input logic [RATIO_W-1:0] ratio,
                                     input logic [GAP_W-1:0]   gap,
                                     input logic [RANGE_W-1:0] invalid);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DISTANCE_RATIO;
        i_cfg_data  <= CFG_W'(ratio);
        @(posedge i_clk);
        i_cfg_index <= CFG_MIN_GAP_MM;
        i_cfg_data  <= CFG_W'(gap);
        @(posedge i_clk);
        i_cfg_index <= CFG_INVALID_CODE;
        i_cfg_data  <= CFG_W'(invalid);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ratio_q15  = ratio;
        gap_mm     = gap;
        invalid_mm = invalid;
    endtask

    task automatic choose_idling;
        sender_gaps   = ($urandom_range(0, 3) != 0);
        burst_left    = 0;
        stall_mode    <= t_stall_mode'($urandom_range(0, 2));
        stall_pattern <= 8'($urandom) & 8'hFE;
    endtask

    // random scans, each closed by a scan end, until at least the given count is sent
    task automatic send_scan_batch(input int unsigned items);
        int unsigned        sent;
        int unsigned        len;
        logic [RANGE_W-1:0] baseline;
        logic [RANGE_W-1:0] sample;
        logic [RANGE_W-1:0] drift;
        logic [THR_W-1:0]   thr;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
            baseline = ($urandom_range(0, 3) == 0) ? RANGE_W'($urandom)
                                                   : RANGE_W'($urandom_range(50, 20000));
            for (int unsigned k = 0; k < len; k++) begin
                thr = (THR_W'(baseline) * THR_W'(ratio_q15) + (THR_W'(gap_mm) << FRAC_W))
                      >> FRAC_W;
                case ($urandom_range(0, 11))
                    0: sample = '0;
                    1: sample = invalid_mm;
                    2: sample = RANGE_W'($urandom);
                    3: sample = RANGE_MAX;
                    4, 5: begin
                        // outlier just either side of the jump threshold
                        if (THR_W'(baseline) + thr + 2 <= THR_W'(RANGE_MAX)) begin
                            sample = baseline + RANGE_W'(thr) + RANGE_W'($urandom_range(0, 2));
                        end else if (THR_W'(baseline) > thr + 2) begin
                            sample = baseline - RANGE_W'(thr) - RANGE_W'($urandom_range(0, 2));
                        end else begin
                            sample = RANGE_W'($urandom);
                        end
                    end
                    default: begin
                        drift = RANGE_W'($urandom_range(0, 120));
                        if ($urandom_range(0, 1) == 1 && baseline > drift) begin
                            baseline = baseline - drift;
                        end else if (baseline <= RANGE_MAX - drift) begin
                            baseline = baseline + drift;
                        end
                        sample = baseline;
                    end
                endcase
                send_sample(sample, k == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_directed_cases;
        sender_gaps = 1'b0;
        stall_mode  <= STALL_NONE;
        send_sample(17'd500, 1'b1);
        send_sample(17'd800, 1'b0);
        send_sample(RANGE_MAX, 1'b1);
        send_sample(17'd1000, 1'b0);
        send_sample(17'd1056, 1'b0);
        send_sample(17'd1000, 1'b0);
        send_sample(17'd1055, 1'b0);
        send_sample(17'd1000, 1'b1);
        // zero and invalid samples are never replaced
        send_sample(17'd5000, 1'b0);
        send_sample(17'd0, 1'b0);
        send_sample(17'd5000, 1'b0);
        send_sample(INVALID_RESET, 1'b0);
        send_sample(17'd5000, 1'b1);
        send_sample(17'd0, 1'b0);
        send_sample(RANGE_MAX, 1'b0);
        send_sample(17'd0, 1'b1);
        wait_all_results();
        // ratio 1.0, no minimum gap: equality must not remove the point
        program_registers(16'd32768, 16'd0, INVALID_RESET);
        send_sample(17'd1000, 1'b0);
        send_sample(17'd2000, 1'b0);
        send_sample(17'd1000, 1'b0);
        send_sample(17'd2001, 1'b0);
        send_sample(17'd1000, 1'b1);
        wait_all_results();
    endtask

    task automatic test_register_extremes;
        program_registers(16'd0, 16'd0, INVALID_RESET);
        choose_idling();
        send_scan_batch(45);
        wait_all_results();
        program_registers(16'hFFFF, 16'hFFFF, RANGE_MAX);
        choose_idling();
        send_scan_batch(45);
        wait_all_results();
        program_registers(16'd0, 16'hFFFF, 17'd0);
        choose_idling();
        send_scan_batch(45);
        wait_all_results();
        program_registers(16'hFFFF, 16'd0, RANGE_W'($urandom));
        choose_idling();
        send_scan_batch(45);
        wait_all_results();
        program_registers(16'($urandom), 16'($urandom), RANGE_W'($urandom));
        choose_idling();
        send_scan_batch(45);
        wait_all_results();
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 8; phase++) begin
            if ($urandom_range(0, 1) == 1) begin
                program_registers(16'($urandom_range(100, 3000)), 16'($urandom_range(0, 200)),
                                  RANGE_W'($urandom_range(60000, 131071)));
            end else begin
                program_registers(16'($urandom), 16'($urandom), RANGE_W'($urandom));
            end
            choose_idling();
            send_scan_batch(40);
            wait_all_results();
        end
    endtask

    task automatic test_output_hold_off;
        program_registers(RATIO_RESET, GAP_RESET, INVALID_RESET);
        sender_gaps   = 1'b0;
        stall_mode    <= STALL_NONE;
        hold_requests <= hold_requests + 1;
        send_scan_batch(40);
        wait_all_results();
        choose_idling();
        hold_requests <= hold_requests + 1;
        send_scan_batch(40);
        wait_all_results();
    endtask

    // receiver: optional long hold-off, then the selected stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                STALL_PATTERN: begin
                    i_stall     <= stall_pattern[pattern_pos];
                    pattern_pos <= pattern_pos + 1'b1;
                end
                default: i_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected result", o_range_out_mm, '0);
            end else begin
                want = expected_samples.pop_front();
                if (o_range_out_mm !== want.range_mm) begin
                    report_mismatch("range_out_mm", o_range_out_mm, want.range_mm);
                end
                if (o_scan_end_out !== want.scan_end) begin
                    report_mismatch("scan_end_out", RANGE_W'(o_scan_end_out),
                                    RANGE_W'(want.scan_end));
                end
            end
        end
    end

    initial begin
        #3_200_000;
        $display("tb_top failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_output_hold_off();
        wait_all_results();
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
